>>> hw/rtl/ppmhp_pkg.sv
package ppmhp_pkg;

  localparam logic [2:0] ST_HEADER  = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_PAYLOAD = 3'd2;
  localparam logic [2:0] ST_MAGIC   = 3'd3;
  localparam logic [2:0] ST_SYNTAX  = 3'd4;
  localparam logic [2:0] ST_NUMBER  = 3'd5;

  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam logic REG_DIM_LIMIT = 1'b0;
  localparam logic [15:0] DIM_LIMIT_RESET = 16'hFFFF;
  localparam logic [16:0] MAXVAL_LIMIT = 17'd65535;
  localparam logic [15:0] WIDE_SAMPLE = 16'd255;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_sample;
    logic [31:0] header_length;
  } ppmhp_snap_t;

endpackage

>>> hw/rtl/ppmhp_parse.sv
module ppmhp_parse import ppmhp_pkg::*; #(
  parameter int DIM_BITS   = 16,
  parameter int MAX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [15:0] dim_limit,
  output ppmhp_snap_t snap
);

  localparam int DW = $clog2(MAX_DIGITS + 1);
  localparam logic [15:0] DIM_CAP = (DIM_BITS >= 16) ? 16'hFFFF :
                                    16'((33'd1 << DIM_BITS) - 33'd1);

  typedef enum logic [3:0] {
    PH_P, PH_SIX, PH_SEP, PH_SKIP, PH_CMT_PRE, PH_DIGITS, PH_CMT_POST,
    PH_PAYLOAD, PH_ERROR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  field_r, field_nxt;
  logic [16:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic [DW-1:0] dcnt_r, dcnt_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] maxval_r, maxval_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [2:0]  err_r, err_nxt;
  ppmhp_snap_t snap_r, snap_nxt;

  logic        done;
  logic        is_space, is_digit, is_hash, is_nl;
  logic [3:0]  digit;
  logic [19:0] acc_mul;
  logic [15:0] dim_eff;
  logic [16:0] limit;
  logic        in_hdr_now, in_hdr_nxt;

  assign is_space = (data_byte == 8'd32) || (data_byte >= 8'd9 && data_byte <= 8'd13);
  assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
  assign is_hash  = (data_byte == 8'h23);
  assign is_nl    = (data_byte == 8'h0A);
  assign digit    = 4'(data_byte - 8'h30);
  assign acc_mul  = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + {16'd0, digit};
  assign dim_eff  = (dim_limit < DIM_CAP) ? dim_limit : DIM_CAP;
  assign limit    = (field_r == 2'd2) ? MAXVAL_LIMIT : {1'b0, dim_eff};
  assign in_hdr_now = (phase_r != PH_PAYLOAD) && (phase_r != PH_ERROR);

  always_comb begin
    phase_nxt  = phase_r;
    field_nxt  = field_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    dcnt_nxt   = dcnt_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    maxval_nxt = maxval_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    done       = 1'b0;

    if (in_hdr_now && cnt_r != 32'hFFFF_FFFF) begin
      cnt_nxt = cnt_r + 32'd1;
    end

    unique case (phase_r)
      PH_P: begin
        if (data_byte == 8'h50) begin
          phase_nxt = PH_SIX;
        end else begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_MAGIC;
        end
      end
      PH_SIX: begin
        if (data_byte == 8'h36) begin
          phase_nxt = PH_SEP;
        end else begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_MAGIC;
        end
      end
      PH_SEP: begin
        if (is_space) begin
          phase_nxt = PH_SKIP;
        end else if (is_hash) begin
          phase_nxt = PH_CMT_PRE;
        end else begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_SYNTAX;
        end
      end
      PH_SKIP: begin
        if (is_space) begin
          phase_nxt = PH_SKIP;
        end else if (is_hash) begin
          phase_nxt = PH_CMT_PRE;
        end else if (is_digit) begin
          acc_nxt   = {13'd0, digit};
          ovf_nxt   = 1'b0;
          dcnt_nxt  = DW'(1);
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_SYNTAX;
        end
      end
      PH_CMT_PRE: begin
        if (is_nl) begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          if (dcnt_r >= DW'(MAX_DIGITS)) begin
            phase_nxt = PH_ERROR;
            err_nxt   = ST_NUMBER;
          end else begin
            if (acc_mul > 20'd65535) begin
              acc_nxt = 17'h10000;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_mul[16:0];
            end
            dcnt_nxt = dcnt_r + DW'(1);
          end
        end else if (ovf_r || acc_r == 17'd0 || acc_r > limit) begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_NUMBER;
        end else begin
          case (field_r)
            2'd0:    width_nxt  = acc_r[15:0];
            2'd1:    height_nxt = acc_r[15:0];
            default: maxval_nxt = acc_r[15:0];
          endcase
          if (is_hash) begin
            phase_nxt = PH_CMT_POST;
          end else if (is_space) begin
            if (field_r >= 2'd2) begin
              phase_nxt = PH_PAYLOAD;
              done      = 1'b1;
            end else begin
              field_nxt = field_r + 2'd1;
              phase_nxt = PH_SKIP;
            end
          end else begin
            phase_nxt = PH_ERROR;
            err_nxt   = ST_SYNTAX;
          end
        end
      end
      PH_CMT_POST: begin
        if (is_nl) begin
          if (field_r >= 2'd2) begin
            phase_nxt = PH_PAYLOAD;
            done      = 1'b1;
          end else begin
            field_nxt = field_r + 2'd1;
            phase_nxt = PH_SKIP;
          end
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    in_hdr_nxt = (phase_nxt != PH_PAYLOAD) && (phase_nxt != PH_ERROR);
    if (last_byte && in_hdr_nxt) begin
      err_nxt   = (phase_nxt == PH_SIX) ? ST_MAGIC : ST_SYNTAX;
      phase_nxt = PH_ERROR;
    end

    if (phase_nxt == PH_ERROR) begin
      snap_nxt.status = err_nxt;
    end else if (done) begin
      snap_nxt.status = ST_DONE;
    end else if (phase_nxt == PH_PAYLOAD) begin
      snap_nxt.status = ST_PAYLOAD;
    end else begin
      snap_nxt.status = ST_HEADER;
    end
    snap_nxt.image_width   = width_nxt;
    snap_nxt.image_height  = height_nxt;
    snap_nxt.max_sample    = maxval_nxt;
    snap_nxt.header_length = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_P;
      field_r  <= 2'd0;
      acc_r    <= 17'd0;
      ovf_r    <= 1'b0;
      dcnt_r   <= '0;
      width_r  <= 16'd0;
      height_r <= 16'd0;
      maxval_r <= 16'd0;
      cnt_r    <= 32'd0;
      err_r    <= 3'd0;
    end else if (accept) begin
      if (last_byte) begin
        phase_r  <= PH_P;
        field_r  <= 2'd0;
        acc_r    <= 17'd0;
        ovf_r    <= 1'b0;
        dcnt_r   <= '0;
        width_r  <= 16'd0;
        height_r <= 16'd0;
        maxval_r <= 16'd0;
        cnt_r    <= 32'd0;
        err_r    <= 3'd0;
      end else begin
        phase_r  <= phase_nxt;
        field_r  <= field_nxt;
        acc_r    <= acc_nxt;
        ovf_r    <= ovf_nxt;
        dcnt_r   <= dcnt_nxt;
        width_r  <= width_nxt;
        height_r <= height_nxt;
        maxval_r <= maxval_nxt;
        cnt_r    <= cnt_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap = snap_r;

endmodule

>>> hw/rtl/ppmhp_size.sv
module ppmhp_size import ppmhp_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  ppmhp_snap_t snap,
  output logic [2:0]  status,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [15:0] max_sample,
  output logic [31:0] header_length,
  output logic [34:0] payload_bytes
);

  logic [31:0] area;
  logic [33:0] triple;
  logic [34:0] size_nxt;
  ppmhp_snap_t snap_r;
  logic [34:0] size_r;

  assign area     = snap.image_width * snap.image_height;
  assign triple   = {1'b0, area, 1'b0} + {2'b00, area};
  assign size_nxt = (snap.max_sample > WIDE_SAMPLE) ? {triple, 1'b0} : {1'b0, triple};

  always_ff @(posedge clk) begin
    if (load) begin
      snap_r <= snap;
      size_r <= size_nxt;
    end
  end

  assign status        = snap_r.status;
  assign image_width   = snap_r.image_width;
  assign image_height  = snap_r.image_height;
  assign max_sample    = snap_r.max_sample;
  assign header_length = snap_r.header_length;
  assign payload_bytes = size_r;

endmodule

>>> hw/rtl/ppm_p6_header_parser_top.sv
// channel   dir  signals                                   request
// in_       in   in_valid in_ready in_data_byte in_last_byte    one file byte
// out_      out  out_valid out_ready out_status ...             one status per byte
// cfg_      in   cfg_psel cfg_penable cfg_pwrite cfg_paddr ...  register access
// one byte accepted per cycle unless out_ready stalls; each status passes
// through both stages: stage one parses the byte and updates header state,
// stage two forms the payload size with one 16x16 multiply and holds the result
// rst_n is synchronous, active low; dimension_limit resets to 65535
// a stalled out_ready holds both stages and drops in_ready only once both are full
module ppm_p6_header_parser_top import ppmhp_pkg::*; #(
  parameter int DIM_BITS   = 16,
  parameter int MAX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [15:0] out_max_sample,
  output logic [31:0] out_header_length,
  output logic [34:0] out_payload_bytes,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        s1_valid_r, s1_valid_nxt;
  logic        s2_valid_r, s2_valid_nxt;
  logic        accept, s2_load;
  logic [15:0] dim_limit_r;
  logic        reg_hit;
  ppmhp_snap_t snap;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[CFG_ADDR_BITS-1] == REG_DIM_LIMIT);
  assign cfg_prdata = reg_hit ? {16'd0, dim_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_limit_r <= DIM_LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      dim_limit_r <= cfg_pwdata[15:0];
    end
  end

  assign s2_load  = s1_valid_r && (!s2_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;
  assign accept   = in_valid && in_ready;
  assign out_valid = s2_valid_r;

  always_comb begin
    s1_valid_nxt = accept ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
    s2_valid_nxt = s2_load ? 1'b1 : (out_ready ? 1'b0 : s2_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  ppmhp_parse #(
    .DIM_BITS   (DIM_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .dim_limit (dim_limit_r),
    .snap      (snap)
  );

  ppmhp_size u_size (
    .clk           (clk),
    .load          (s2_load),
    .snap          (snap),
    .status        (out_status),
    .image_width   (out_image_width),
    .image_height  (out_image_height),
    .max_sample    (out_max_sample),
    .header_length (out_header_length),
    .payload_bytes (out_payload_bytes)
  );

endmodule
